// File: hw/rtl/lgs_pkg.sv
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and the Life B3/S23 row rule for the generation step.
// ---------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    typedef logic [63:0] row_t;
    typedef logic [6:0]  width_t;
    typedef logic [12:0] height_t;
    typedef logic [11:0] index_t;
    typedef logic [12:0] cfg_data_t;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_WRAP_EDGES  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_MAIN  = 2'd0,
        PH_FINAL = 2'd1,
        PH_WRAP  = 2'd2
    } phase_t;

    localparam width_t  WIDTH_MIN   = width_t'(MIN_SIZE);
    localparam width_t  WIDTH_MAX   = width_t'(MAX_WIDTH);
    localparam height_t HEIGHT_MIN  = height_t'(MIN_SIZE);
    localparam height_t HEIGHT_MAX  = height_t'(MAX_HEIGHT);
    localparam width_t  WIDTH_RESET = width_t'(64);
    localparam height_t HEIGHT_RESET = height_t'(64);

    // One row's worth of work handed from the window to the emitter
    typedef struct packed {
        row_t   above;
        row_t   middle;
        row_t   current;
        row_t   first;
        row_t   second;
        index_t row;
        logic   final_row;
        width_t width;
        logic   wrap;
    } job_t;

    function automatic row_t width_mask(input width_t w);
        row_t m;
        if (w >= WIDTH_MAX)
        begin
            m = '1;
        end
        else
        begin
            m = (row_t'(1) << w) - row_t'(1);
        end
        return m;
    endfunction

    // Next state of the middle row; w is already clamped to 3..64
    function automatic row_t life_row(input row_t up, input row_t mid, input row_t down,
                                      input width_t w, input logic wrap);
        row_t       mask;
        row_t       u;
        row_t       m;
        row_t       d;
        row_t       res;
        logic [5:0] last_col;
        logic [5:0] li;
        logic [5:0] ri;
        logic       has_l;
        logic       has_r;
        logic [3:0] n;
        mask     = width_mask(w);
        u        = up & mask;
        m        = mid & mask;
        d        = down & mask;
        res      = '0;
        last_col = 6'(w - width_t'(1));
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            if (x == 0)
            begin
                has_l = wrap;
                li    = last_col;
            end
            else
            begin
                has_l = 1'b1;
                li    = 6'(x - 1);
            end
            if (width_t'(x + 1) >= w)
            begin
                has_r = wrap;
                ri    = 6'd0;
            end
            else
            begin
                has_r = 1'b1;
                ri    = 6'(x + 1);
            end
            n = 4'(u[x]) + 4'(d[x])
              + 4'(has_l & u[li]) + 4'(has_l & m[li]) + 4'(has_l & d[li])
              + 4'(has_r & u[ri]) + 4'(has_r & m[ri]) + 4'(has_r & d[ri]);
            res[x] = (n == 4'd3) || ((n == 4'd2) && m[x]);
        end
        return res & mask;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lgs_if.sv
// ---------------------------------------------------------------------------
// lgs_row_if / lgs_result_if
// Valid/ready channels for incoming grid rows and outgoing next-generation rows.
// ---------------------------------------------------------------------------
`default_nettype none

interface lgs_row_if;
    import lgs_pkg::*;
    logic valid;
    logic ready;
    row_t row_cells;

    modport source (output valid, output row_cells, input ready);
    modport sink   (input valid, input row_cells, output ready);
endinterface

interface lgs_result_if;
    import lgs_pkg::*;
    logic   valid;
    logic   ready;
    row_t   next_row_cells;
    index_t row_index;
    logic   last_of_generation;

    modport source (output valid, output next_row_cells, output row_index,
                    output last_of_generation, input ready);
    modport sink   (input valid, input next_row_cells, input row_index,
                    input last_of_generation, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lgs_window.sv
// ---------------------------------------------------------------------------
// lgs_window
// Row window: keeps last two rows and rows 0/1, registers a job per row >= 2.
// ---------------------------------------------------------------------------
`default_nettype none

module lgs_window
    import lgs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire width_t  grid_width,
    input  wire height_t grid_height,
    input  wire logic    wrap_edges,
    lgs_row_if.sink      row_in,
    output job_t         job,
    output logic         job_valid,
    input  wire logic    job_ready
);

    index_t  rows_seen_reg;
    index_t  rows_seen_next;
    row_t    above_reg;
    row_t    middle_reg;
    row_t    first_reg;
    row_t    second_reg;
    job_t    job_reg;
    logic    job_valid_reg;
    logic    job_valid_next;

    width_t  used_w;
    height_t used_h;
    row_t    cur;
    logic    accept;
    logic    is_final;
    logic    makes_job;

    always_comb
    begin
        if (grid_width < WIDTH_MIN)
        begin
            used_w = WIDTH_MIN;
        end
        else if (grid_width > WIDTH_MAX)
        begin
            used_w = WIDTH_MAX;
        end
        else
        begin
            used_w = grid_width;
        end
        if (grid_height < HEIGHT_MIN)
        begin
            used_h = HEIGHT_MIN;
        end
        else if (grid_height > HEIGHT_MAX)
        begin
            used_h = HEIGHT_MAX;
        end
        else
        begin
            used_h = grid_height;
        end
    end

    assign row_in.ready = !job_valid_reg || job_ready;
    assign accept       = row_in.valid && row_in.ready;
    assign cur          = row_in.row_cells & width_mask(used_w);
    assign makes_job    = rows_seen_reg >= index_t'(2);
    assign is_final     = (height_t'(rows_seen_reg) + height_t'(1)) >= used_h;

    always_comb
    begin
        rows_seen_next = rows_seen_reg;
        job_valid_next = job_valid_reg && !job_ready;
        if (accept)
        begin
            if (!makes_job)
            begin
                rows_seen_next = rows_seen_reg + index_t'(1);
            end
            else
            begin
                job_valid_next = 1'b1;
                rows_seen_next = is_final ? index_t'(0) : rows_seen_reg + index_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_seen_reg <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            rows_seen_reg <= rows_seen_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (rows_seen_reg == index_t'(0))
            begin
                first_reg <= cur;
            end
            if (rows_seen_reg == index_t'(1))
            begin
                second_reg <= cur;
            end
            if (rows_seen_reg != index_t'(0))
            begin
                above_reg <= middle_reg;
            end
            middle_reg <= cur;
            if (makes_job)
            begin
                job_reg.above     <= above_reg;
                job_reg.middle    <= middle_reg;
                job_reg.current   <= cur;
                job_reg.first     <= first_reg;
                job_reg.second    <= second_reg;
                job_reg.row       <= rows_seen_reg;
                job_reg.final_row <= is_final;
                job_reg.width     <= used_w;
                job_reg.wrap      <= wrap_edges;
            end
        end
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lgs_emit.sv
// ---------------------------------------------------------------------------
// lgs_emit
// Life rule on a job; registers one result beat per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module lgs_emit
    import lgs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire job_t    job,
    input  wire logic    job_valid,
    output logic         job_ready,
    lgs_result_if.source result_out
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    row_t   cells_reg;
    index_t index_reg;
    logic   last_reg;

    row_t   sel_up;
    row_t   sel_mid;
    row_t   sel_down;
    index_t sel_index;
    logic   sel_last;
    logic   last_phase;
    logic   load;

    always_comb
    begin
        sel_up     = job.above;
        sel_mid    = job.middle;
        sel_down   = job.current;
        sel_index  = job.row - index_t'(1);
        sel_last   = 1'b0;
        last_phase = !job.final_row;
        unique case (phase_reg)
            PH_MAIN:
            begin
                sel_up    = job.above;
                sel_mid   = job.middle;
                sel_down  = job.current;
                sel_index = job.row - index_t'(1);
            end
            PH_FINAL:
            begin
                sel_up    = job.middle;
                sel_mid   = job.current;
                sel_down  = job.wrap ? job.first : '0;
                sel_index = job.row;
            end
            PH_WRAP:
            begin
                sel_up     = job.wrap ? job.current : '0;
                sel_mid    = job.first;
                sel_down   = job.second;
                sel_index  = '0;
                sel_last   = 1'b1;
                last_phase = 1'b1;
            end
            default:
            begin
                last_phase = 1'b1;
            end
        endcase
    end

    assign load      = job_valid && (!out_valid_reg || result_out.ready);
    assign job_ready = load && last_phase;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (last_phase)
            begin
                phase_next = PH_MAIN;
            end
            else if (phase_reg == PH_MAIN)
            begin
                phase_next = PH_FINAL;
            end
            else
            begin
                phase_next = PH_WRAP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cells_reg <= life_row(sel_up, sel_mid, sel_down, job.width, job.wrap);
            index_reg <= sel_index;
            last_reg  <= sel_last;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.next_row_cells     = cells_reg;
    assign result_out.row_index          = index_reg;
    assign result_out.last_of_generation = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/life_generation_step_unit.sv
// ---------------------------------------------------------------------------
// life_generation_step_unit
// One generation of Life (B3/S23), streamed a row at a time.
// ---------------------------------------------------------------------------
// Rows of the current grid arrive on row_in, row 0 first, one 64-cell row per
// beat. Next-generation rows leave on result_out with their row index; row 0
// of each generation is the final beat and carries last_of_generation.
// Rows 0 and 1 give no beat; row r (r >= 2) gives row r-1, and the final row
// gives rows H-2, H-1 and then row 0.
// A row's result passes the window's job register, then the output register.
// Throughput: one row per cycle unless stalled; after the final row the input
// is held off while its three beats go into the output register one by one.
// Configuration (grid_width, grid_height, wrap_edges) is written through
// cfg_wr_en / cfg_index / cfg_data, by the user only while the block is idle;
// the block does not enforce this. Reset clears the row count and all valid
// flags; the first row after reset is row 0. A stalled receiver holds the
// output register, one job waits behind it, and row_in.ready drops when both
// are full or while a final row's three beats go out.
// ---------------------------------------------------------------------------
`default_nettype none

module life_generation_step_unit
    import lgs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire cfg_index_t cfg_index,
    input  wire cfg_data_t  cfg_data,
    lgs_row_if.sink         row_in,
    lgs_result_if.source    result_out
);

    width_t  grid_width_reg;
    height_t grid_height_reg;
    logic    wrap_edges_reg;

    job_t    job;
    logic    job_valid;
    logic    job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= WIDTH_RESET;
            grid_height_reg <= HEIGHT_RESET;
            wrap_edges_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= width_t'(cfg_data);
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                CFG_WRAP_EDGES:  wrap_edges_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lgs_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .wrap_edges  (wrap_edges_reg),
        .row_in      (row_in),
        .job         (job),
        .job_valid   (job_valid),
        .job_ready   (job_ready)
    );

    lgs_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// File: verif/life_generation_step_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_generation_step_unit_test
// Self-checking bench for the streamed Life B3/S23 generation step.
// ---------------------------------------------------------------------------
// Rows are fed from a queue by a falling-edge driver. A rising-edge monitor
// runs a row-window model of the block on every accepted row beat, and each
// result beat is checked field by field against the oldest prediction.
// Grid size and edge mode are rewritten between generations, and mid-way
// through some, with four mixes of sender idling and receiver stalls.
// ---------------------------------------------------------------------------

module life_generation_step_unit_test
    import lgs_pkg::*;
();

    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ROWS    = 60;

    typedef struct {
        row_t   cells;
        index_t index;
        logic   last;
    } gen_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    lgs_row_if    row_if ();
    lgs_result_if result_if ();

    life_generation_step_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .row_in     (row_if),
        .result_out (result_if)
    );

    // register copies and row window of the model
    width_t  grid_width_copy  = WIDTH_RESET;
    height_t grid_height_copy = HEIGHT_RESET;
    logic    wrap_copy        = 1'b0;
    index_t  window_count     = '0;
    row_t    window_above     = '0;
    row_t    window_middle    = '0;
    row_t    first_row_copy   = '0;
    row_t    second_row_copy  = '0;

    row_t     pending_rows [$];
    gen_row_t expected_gen_rows [$];

    int   send_idle_pct    = 0;
    int   stall_pct        = 0;
    logic row_beat_taken   = 1'b0;
    int   rows_fed         = 0;
    int   rows_checked     = 0;
    int   generations_seen = 0;
    int   mismatch_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Run did not drain in time: %0d predictions outstanding",
                 expected_gen_rows.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int used_width();
        int w;
        w = int'(grid_width_copy);
        if (w < MIN_SIZE)
            w = MIN_SIZE;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int used_height();
        int h;
        h = int'(grid_height_copy);
        if (h < MIN_SIZE)
            h = MIN_SIZE;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic row_t active_mask(int w);
        return ~(row_t'('1) << w);
    endfunction

    function automatic row_t next_generation_row(row_t up, row_t mid, row_t down,
                                                 int w, logic wrap);
        row_t nbr_rows [3];
        row_t keep;
        row_t born;
        int   col;
        int   live;
        keep        = active_mask(w);
        nbr_rows[0] = up & keep;
        nbr_rows[1] = mid & keep;
        nbr_rows[2] = down & keep;
        born        = '0;
        for (int x = 0; x < w; x++)
        begin
            live = 0;
            for (int dy = 0; dy < 3; dy++)
            begin
                for (int dx = -1; dx <= 1; dx++)
                begin
                    col = x + dx;
                    if (wrap)
                        col = (col + w) % w;
                    if ((dy != 1 || dx != 0) && col >= 0 && col < w)
                        live += int'(nbr_rows[dy][col]);
                end
            end
            born[x] = (live == 3) || (live == 2 && nbr_rows[1][x]);
        end
        return born;
    endfunction

    function automatic void expect_gen_row(row_t cells, int index, logic last);
        gen_row_t item;
        item.cells = cells;
        item.index = index_t'(index);
        item.last  = last;
        expected_gen_rows.push_back(item);
    endfunction

    function automatic void advance_window(row_t raw);
        int   w;
        int   h;
        int   r;
        logic wrap;
        row_t cur;
        w    = used_width();
        h    = used_height();
        wrap = wrap_copy;
        cur  = raw & active_mask(w);
        r    = int'(window_count);
        if (r == 0)
        begin
            first_row_copy = cur;
            window_middle  = cur;
            window_count   = index_t'(1);
        end
        else if (r == 1)
        begin
            second_row_copy = cur;
            window_above    = window_middle;
            window_middle   = cur;
            window_count    = index_t'(2);
        end
        else
        begin
            expect_gen_row(next_generation_row(window_above, window_middle, cur, w, wrap),
                           r - 1, 1'b0);
            if (r + 1 >= h)
            begin
                expect_gen_row(next_generation_row(window_middle, cur,
                                                   wrap ? first_row_copy : '0, w, wrap),
                               r, 1'b0);
                expect_gen_row(next_generation_row(wrap ? cur : '0, first_row_copy,
                                                   second_row_copy, w, wrap),
                               0, 1'b1);
                window_count = '0;
            end
            else
            begin
                window_count = index_t'(r + 1);
            end
            window_above  = window_middle;
            window_middle = cur;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    // driver: presents the next queued row beat at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            row_if.valid <= 1'b0;
        end
        else if (!row_if.valid || row_beat_taken)
        begin
            if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                row_if.valid     <= 1'b1;
                row_if.row_cells <= pending_rows.pop_front();
            end
            else
            begin
                row_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: model update on row beats, check on result beats
    always @(posedge clk)
    begin
        gen_row_t want;
        row_beat_taken = rst_n && row_if.valid && row_if.ready;
        if (row_beat_taken)
        begin
            rows_fed++;
            advance_window(row_if.row_cells);
        end
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_gen_rows.size() == 0)
            begin
                report_mismatch("result beat with nothing expected, cells",
                                result_if.next_row_cells, '0);
            end
            else
            begin
                want = expected_gen_rows.pop_front();
                rows_checked++;
                if (result_if.last_of_generation === 1'b1)
                    generations_seen++;
                if (result_if.next_row_cells !== want.cells)
                    report_mismatch($sformatf("next_row_cells of row %0d", want.index),
                                    result_if.next_row_cells, want.cells);
                if (result_if.row_index !== want.index)
                    report_mismatch("row_index", 64'(result_if.row_index),
                                    64'(want.index));
                if (result_if.last_of_generation !== want.last)
                    report_mismatch($sformatf("last_of_generation of row %0d", want.index),
                                    64'(result_if.last_of_generation), 64'(want.last));
            end
        end
    end

    function automatic row_t random_row();
        row_t a;
        row_t b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       return a & b & {$urandom, $urandom};
            1:       return a & b;
            2:       return a | b;
            3:       return $urandom_range(1) ? row_t'('0) : row_t'('1);
            default: return a;
        endcase
    endfunction

    task automatic write_register(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cfg_data_t'(value);
        case (idx)
            CFG_GRID_WIDTH:  grid_width_copy  = width_t'(value);
            CFG_GRID_HEIGHT: grid_height_copy = height_t'(value);
            CFG_WRAP_EDGES:  wrap_copy        = value[0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_rows(int count);
        for (int i = 0; i < count; i++)
            pending_rows.push_back(random_row());
    endtask

    // a row popped at the same falling edge only shows on valid a step later
    task automatic wait_drained();
        do
        begin
            while (pending_rows.size() != 0 || row_if.valid
                   || expected_gen_rows.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
        while (pending_rows.size() != 0 || row_if.valid || expected_gen_rows.size() != 0);
    endtask

    function automatic int pick_width();
        case ($urandom_range(9))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(65, 127);
            2:       return MAX_WIDTH;
            default: return $urandom_range(3, 63);
        endcase
    endfunction

    function automatic int pick_height();
        case ($urandom_range(7))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(11, 40);
            default: return $urandom_range(3, 10);
        endcase
    endfunction

    initial
    begin
        int idle_send [4];
        int idle_recv [4];
        int phase_rows;
        int h;
        int k;
        int c;
        int rest;
        idle_send = '{0, 57, 0, 24};
        idle_recv = '{0, 0, 57, 24};

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_GRID_WIDTH;
        cfg_data         = '0;
        row_if.valid     = 1'b0;
        row_if.row_cells = '0;
        result_if.ready  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: full width, dead edges, smallest grid
        write_register(CFG_GRID_WIDTH, MAX_WIDTH);
        write_register(CFG_GRID_HEIGHT, 3);
        write_register(CFG_WRAP_EDGES, 0);
        pending_rows.push_back('1);
        pending_rows.push_back('0);
        pending_rows.push_back('1);
        wait_drained();

        write_register(CFG_WRAP_EDGES, 1);
        pending_rows.push_back('1);
        pending_rows.push_back(64'h5555_5555_5555_5555);
        pending_rows.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();

        // sizes below the minimum, junk above the active width
        write_register(CFG_GRID_WIDTH, 0);
        write_register(CFG_GRID_HEIGHT, 0);
        pending_rows.push_back(64'h8000_0000_0000_0007);
        pending_rows.push_back(64'hFFFF_FFFF_FFFF_FFFA);
        pending_rows.push_back(64'hF0F0_0000_0000_0005);
        wait_drained();

        write_register(CFG_GRID_WIDTH, 127);
        write_register(CFG_GRID_HEIGHT, 2);
        write_register(CFG_WRAP_EDGES, 0);
        queue_random_rows(3);
        wait_drained();

        // blinker on a small torus
        write_register(CFG_GRID_WIDTH, 5);
        write_register(CFG_GRID_HEIGHT, 4);
        write_register(CFG_WRAP_EDGES, 1);
        pending_rows.push_back(64'h4);
        pending_rows.push_back(64'h4);
        pending_rows.push_back(64'h4);
        pending_rows.push_back(64'h0);
        wait_drained();

        // settings changed part-way, then height cut below the rows already in
        write_register(CFG_GRID_WIDTH, 10);
        write_register(CFG_GRID_HEIGHT, 8);
        write_register(CFG_WRAP_EDGES, 0);
        queue_random_rows(4);
        wait_drained();
        write_register(CFG_GRID_WIDTH, 6);
        write_register(CFG_WRAP_EDGES, 1);
        queue_random_rows(2);
        wait_drained();
        write_register(CFG_GRID_HEIGHT, 3);
        queue_random_rows(1);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_send[p];
            stall_pct     = idle_recv[p];
            phase_rows    = 0;
            while (phase_rows < PHASE_ROWS)
            begin
                write_register(CFG_GRID_WIDTH, pick_width());
                write_register(CFG_GRID_HEIGHT, pick_height());
                write_register(CFG_WRAP_EDGES, $urandom_range(1));
                h = used_height();
                if ($urandom_range(3) == 0)
                begin
                    // sender holds until every result is out, then carries on
                    k = $urandom_range(1, h - 1);
                    queue_random_rows(k);
                    wait_drained();
                    case ($urandom_range(2))
                        0:       write_register(CFG_GRID_WIDTH, pick_width());
                        1:       write_register(CFG_WRAP_EDGES, !wrap_copy);
                        default: write_register(CFG_GRID_HEIGHT, $urandom_range(0, 12));
                    endcase
                    c    = int'(window_count);
                    h    = used_height();
                    rest = (c + 1 >= h) ? 1 : h - c;
                    queue_random_rows(rest);
                    phase_rows += k + rest;
                end
                else
                begin
                    queue_random_rows(h);
                    phase_rows += h;
                end
                wait_drained();
            end
        end

        // height beyond the field's clamp, generation closed by cutting it
        send_idle_pct = 0;
        stall_pct     = 0;
        write_register(CFG_GRID_WIDTH, $urandom_range(3, 64));
        write_register(CFG_GRID_HEIGHT, 8191);
        write_register(CFG_WRAP_EDGES, 1);
        queue_random_rows(20);
        wait_drained();
        write_register(CFG_GRID_HEIGHT, 3);
        queue_random_rows(1);
        wait_drained();

        $display("Checked %0d next-generation rows from %0d input rows, %0d generations.",
                 rows_checked, rows_fed, generations_seen);
        $display("Widths and heights across their clamps, both edge modes,");
        $display("mid-generation changes.");
        if (mismatch_count == 0 && expected_gen_rows.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
